### rtl/dtfx_pkg.sv
// ----------------------------------------------------------------------------
// dtfx_pkg
// Shared types, constants and helper functions for the decimal text to
// fixed point converter.
// ----------------------------------------------------------------------------
package dtfx_pkg;

	localparam int FRACTION_DIGITS = 9;
	localparam int FRACTION_BITS   = 32;
	localparam int QUEUE_DEPTH     = 2;

	localparam int INT_W   = 31;
	localparam int FSUM_W  = 30;
	localparam int FCNT_W  = 4;
	localparam int VALUE_W = 64;
	localparam int STEP_W  = $clog2(FRACTION_BITS + 1);
	localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	localparam logic [INT_W-1:0] INT_MAX = {INT_W{1'b1}};

	typedef enum logic [2:0] {
		PH_SIGN,
		PH_INT,
		PH_INT_SKIP,
		PH_FRAC,
		PH_FRAC_SKIP
	} phase_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_DONE
	} back_state_t;

	// One parsed number waiting for fraction scaling.
	typedef struct packed {
		logic              negative;
		logic [INT_W-1:0]  integer_sum;
		logic [FSUM_W-1:0] fraction_sum;
		logic [FCNT_W-1:0] fraction_count;
		logic              invalid;
		logic              overflow;
	} number_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	function automatic logic [FSUM_W-1:0] pow10(input logic [FCNT_W-1:0] cnt);
		logic [FSUM_W-1:0] r;
		case (cnt)
			4'd0:    r = 30'd1;
			4'd1:    r = 30'd10;
			4'd2:    r = 30'd100;
			4'd3:    r = 30'd1000;
			4'd4:    r = 30'd10000;
			4'd5:    r = 30'd100000;
			4'd6:    r = 30'd1000000;
			4'd7:    r = 30'd10000000;
			4'd8:    r = 30'd100000000;
			default: r = 30'd1000000000;
		endcase
		return r;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

endpackage

### rtl/dtfx_if.sv
// ----------------------------------------------------------------------------
// dtfx_if
// Valid/ready channels for text characters and for converted numbers.
// ----------------------------------------------------------------------------
interface dtfx_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       end_of_text;

	modport source (output valid, output character, output end_of_text, input ready);
	modport sink   (input valid, input character, input end_of_text, output ready);
endinterface

interface dtfx_number_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] value;
	logic               invalid;
	logic               overflow;

	modport source (output valid, output value, output invalid, output overflow, input ready);
	modport sink   (input valid, input value, input invalid, input overflow, output ready);
endinterface

### rtl/dtfx_front.sv
// ----------------------------------------------------------------------------
// dtfx_front
// Character parser: sign, integer and fraction digits, error skipping.
// Pushes one parsed number into the queue when a number ends.
// ----------------------------------------------------------------------------
module dtfx_front
	import dtfx_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid,
	output logic          ready,
	input  logic [7:0]    character,
	input  logic          end_of_text,
	input  queue_status_t qstat,
	output logic          push,
	output number_t       push_data
);

	phase_t            phase_q, phase_d;
	logic              negative_q, negative_d;
	logic [INT_W-1:0]  isum_q, isum_d;
	logic [FSUM_W-1:0] fsum_q, fsum_d;
	logic [FCNT_W-1:0] fcnt_q, fcnt_d;
	logic              inv_q, inv_d;
	logic              ovf_q, ovf_d;

	logic              fire;
	logic              digit;
	logic              space;
	logic [3:0]        dval;
	logic [INT_W+3:0]  int_next;
	logic [FSUM_W+3:0] frac_next;
	logic              done;

	assign ready = !qstat.full;
	assign fire  = valid && ready;
	assign digit = is_digit(character);
	assign space = is_space(character);
	assign dval  = 4'(character - CH_ZERO);

	assign int_next  = ({4'd0, isum_q} << 3) + ({4'd0, isum_q} << 1) + (INT_W + 4)'(dval);
	assign frac_next = ({4'd0, fsum_q} << 3) + ({4'd0, fsum_q} << 1) + (FSUM_W + 4)'(dval);

	always_comb begin
		phase_d = phase_q;
		done    = 1'b0;
		case (phase_q)
			PH_SIGN: begin
				if (character == CH_MINUS || character == CH_PLUS || digit) begin
					phase_d = PH_INT;
				end else if (character == CH_DOT) begin
					phase_d = PH_FRAC;
				end else begin
					phase_d = PH_INT_SKIP;
				end
			end
			PH_INT: begin
				if (character == CH_DOT) begin
					phase_d = PH_FRAC;
				end else if (!digit) begin
					phase_d = PH_INT_SKIP;
				end
			end
			PH_INT_SKIP: begin
				if (character == CH_DOT) begin
					phase_d = PH_FRAC;
				end
			end
			PH_FRAC: begin
				if (space) begin
					done = 1'b1;
				end else if (!digit) begin
					phase_d = PH_FRAC_SKIP;
				end
			end
			PH_FRAC_SKIP: begin
				done = space;
			end
			default: begin
				phase_d = PH_SIGN;
			end
		endcase
	end

	always_comb begin
		negative_d = negative_q;
		isum_d     = isum_q;
		fsum_d     = fsum_q;
		fcnt_d     = fcnt_q;
		inv_d      = inv_q;
		ovf_d      = ovf_q;
		case (phase_q)
			PH_SIGN: begin
				if (character == CH_MINUS) begin
					negative_d = 1'b1;
				end else if (character == CH_PLUS || character == CH_DOT) begin
					negative_d = negative_q;
				end else if (!digit) begin
					inv_d = 1'b1;
				end
			end
			PH_INT: begin
				if (character != CH_DOT && !digit) begin
					inv_d = 1'b1;
				end
			end
			PH_FRAC: begin
				if (digit) begin
					if (fcnt_q < FCNT_W'(FRACTION_DIGITS)) begin
						fsum_d = frac_next[FSUM_W-1:0];
						fcnt_d = fcnt_q + 1'b1;
					end
				end else if (!space) begin
					inv_d = 1'b1;
				end
			end
			default: begin
				inv_d = inv_q;
			end
		endcase
		if ((phase_q == PH_SIGN || phase_q == PH_INT) && digit) begin
			if (int_next > (INT_W + 4)'(INT_MAX)) begin
				isum_d = INT_MAX;
				ovf_d  = 1'b1;
			end else begin
				isum_d = int_next[INT_W-1:0];
			end
		end
	end

	assign push = fire && (done || end_of_text);

	always_comb begin
		push_data.negative       = negative_d;
		push_data.integer_sum    = isum_d;
		push_data.fraction_sum   = fsum_d;
		push_data.fraction_count = fcnt_d;
		push_data.invalid        = inv_d;
		push_data.overflow       = ovf_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SIGN;
			negative_q <= 1'b0;
			isum_q     <= '0;
			fsum_q     <= '0;
			fcnt_q     <= '0;
			inv_q      <= 1'b0;
			ovf_q      <= 1'b0;
		end else if (fire) begin
			if (push) begin
				phase_q    <= PH_SIGN;
				negative_q <= 1'b0;
				isum_q     <= '0;
				fsum_q     <= '0;
				fcnt_q     <= '0;
				inv_q      <= 1'b0;
				ovf_q      <= 1'b0;
			end else begin
				phase_q    <= phase_d;
				negative_q <= negative_d;
				isum_q     <= isum_d;
				fsum_q     <= fsum_d;
				fcnt_q     <= fcnt_d;
				inv_q      <= inv_d;
				ovf_q      <= ovf_d;
			end
		end
	end

endmodule

### rtl/dtfx_queue.sv
// ----------------------------------------------------------------------------
// dtfx_queue
// Short first-in first-out queue of parsed numbers between parser and scaler.
// ----------------------------------------------------------------------------
module dtfx_queue
	import dtfx_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  number_t       push_data,
	input  logic          pop,
	output number_t       pop_data,
	output queue_status_t qstat
);

	number_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign qstat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign pop_data    = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/dtfx_back.sv
// ----------------------------------------------------------------------------
// dtfx_back
// Fraction scaler: radix-2 long division of the fraction digits by a power
// of ten, sign application and the output register.
// ----------------------------------------------------------------------------
module dtfx_back
	import dtfx_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  queue_status_t qstat,
	input  number_t       pop_data,
	output logic          pop,
	dtfx_number_if.source number
);

	back_state_t              state_q, state_d;
	number_t                  job_q;
	logic [FSUM_W:0]          rem_q;
	logic [FSUM_W-1:0]        div_q;
	logic [FRACTION_BITS-1:0] quot_q;
	logic [STEP_W-1:0]        step_q;
	logic                     out_valid_q;
	logic signed [VALUE_W-1:0] value_q;
	logic                     invalid_q;
	logic                     overflow_q;

	logic [FSUM_W:0]          trial;
	logic                     qbit;
	logic                     load_out;
	logic [31:0]              frac32;
	logic [VALUE_W-1:0]       mag;
	logic [VALUE_W-1:0]       signed_mag;

	assign trial = {rem_q[FSUM_W-1:0], 1'b0};
	assign qbit  = (trial >= {1'b0, div_q});

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!qstat.empty) begin
					state_d = BK_DIV;
				end
			end
			BK_DIV: begin
				if (step_q == STEP_W'(FRACTION_BITS - 1)) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				if (!out_valid_q || number.ready) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		load_out = 1'b0;
		case (state_q)
			BK_IDLE: pop      = !qstat.empty;
			BK_DONE: load_out = !out_valid_q || number.ready;
			default: begin
				pop      = 1'b0;
				load_out = 1'b0;
			end
		endcase
	end

	assign frac32     = 32'(quot_q) << (32 - FRACTION_BITS);
	assign mag        = {1'b0, job_q.integer_sum, frac32};
	assign signed_mag = job_q.negative ? (~mag + 1'b1) : mag;

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q  <= pop_data;
			rem_q  <= {1'b0, pop_data.fraction_sum};
			div_q  <= pow10(pop_data.fraction_count);
			quot_q <= '0;
			step_q <= '0;
		end else if (state_q == BK_DIV) begin
			rem_q  <= qbit ? (trial - {1'b0, div_q}) : trial;
			quot_q <= {quot_q[FRACTION_BITS-2:0], qbit};
			step_q <= step_q + 1'b1;
		end
		if (load_out) begin
			value_q    <= job_q.invalid ? '0 : signed_mag;
			invalid_q  <= job_q.invalid;
			overflow_q <= job_q.overflow;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (number.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign number.valid    = out_valid_q;
	assign number.value    = value_q;
	assign number.invalid  = invalid_q;
	assign number.overflow = overflow_q;

endmodule

### rtl/decimal_text_to_fixed_point.sv
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point
// Converts decimal text, one character per request, into signed Q31.32.
// ----------------------------------------------------------------------------
// The text channel takes one ASCII character per request, with end_of_text
// set on the final character. The number channel returns one request per
// parsed number: value, invalid and overflow.
// The parser takes a character every cycle while its queue has room. A number
// ends on whitespace after the dot or on the final character; it then waits in
// a two-entry queue for the scaler.
// The scaler divides the fraction digits by a power of ten one quotient bit
// per cycle, and takes a new number from the queue only once it has loaded
// the last one into the output register, while the characters inside a
// number stream at one per cycle as long as the queue has room.
// Reset clears the parser, the queue, the scaler state and the output valid flag.
// When the receiver stalls, the result holds in the output register, the
// scaler holds its finished number, the queue fills and then the text channel
// drops ready.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_point
	import dtfx_pkg::*;
(
	input logic           clk,
	input logic           arst_n,
	dtfx_text_if.sink     text,
	dtfx_number_if.source number
);

	queue_status_t qstat;
	logic          push;
	number_t       push_data;
	logic          pop;
	number_t       pop_data;

	dtfx_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid       (text.valid),
		.ready       (text.ready),
		.character   (text.character),
		.end_of_text (text.end_of_text),
		.qstat       (qstat),
		.push        (push),
		.push_data   (push_data)
	);

	dtfx_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.qstat     (qstat)
	);

	dtfx_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qstat    (qstat),
		.pop_data (pop_data),
		.pop      (pop),
		.number   (number)
	);

endmodule

### rtl/dtfx_checker.sv
// ----------------------------------------------------------------------------
// dtfx_checker
// Port-level assertions for the converter, bound to the top level.
// ----------------------------------------------------------------------------
module dtfx_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] out_value,
	input logic        out_invalid,
	input logic        out_overflow
);

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Result request dropped while stalled.");

	a_value_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_value))
		else $error("Result value changed while stalled.");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_invalid |-> out_value == 64'd0)
		else $error("Invalid result carries a nonzero value.");

	a_overflow_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_overflow && !out_invalid && !out_value[63]
		|-> out_value[62:32] == 31'h7FFFFFFF)
		else $error("Positive overflow result is not saturated.");

endmodule

bind decimal_text_to_fixed_point dtfx_checker u_dtfx_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (number.valid),
	.out_ready    (number.ready),
	.out_value    (number.value),
	.out_invalid  (number.invalid),
	.out_overflow (number.overflow)
);
